>>> rtl/cdbst_pkg.sv
// ----------------------------------------------------------------------------
// cdbst_pkg
// Shared types, codes and reset constants of the carrier-detect backoff
// serial transceiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdbst_pkg;

    // Line modes, also reported on the result word.
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_RX      = 3'd1,
        MODE_TX      = 3'd2,
        MODE_BACKOFF = 3'd3,
        MODE_COLL    = 3'd4
    } mode_t;

    // Send request status codes.
    localparam logic [2:0] STATUS_NONE     = 3'd0;
    localparam logic [2:0] STATUS_STARTED  = 3'd1;
    localparam logic [2:0] STATUS_CARRIER  = 3'd2;
    localparam logic [2:0] STATUS_PRIORITY = 3'd3;
    localparam logic [2:0] STATUS_BUSY     = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TICKS_PER_BIT   = 3'd0;
    localparam logic [2:0] CFG_FIRST_SAMPLE    = 3'd1;
    localparam logic [2:0] CFG_CARRIER_TICKS   = 3'd2;
    localparam logic [2:0] CFG_BACKOFF_LIMIT   = 3'd3;
    localparam logic [2:0] CFG_COLLISION_TICKS = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_TICKS_PER_BIT   = 8'd10;
    localparam logic [7:0] RST_FIRST_SAMPLE    = 8'd15;
    localparam logic [6:0] RST_CARRIER_TICKS   = 7'd20;
    localparam logic [6:0] RST_BACKOFF_LIMIT   = 7'd40;
    localparam logic [6:0] RST_COLLISION_TICKS = 7'd15;

    // Data bits in one byte and the saturation point of the bit counter.
    localparam logic [6:0] DATA_BITS = 7'd8;
    localparam logic [6:0] COUNT_MAX = 7'd127;

    typedef struct packed {
        logic [7:0] ticks_per_bit;
        logic [7:0] first_sample_ticks;
        logic [6:0] carrier_ticks;
        logic [6:0] backoff_limit;
        logic [6:0] collision_ticks;
    } cfg_t;

    typedef struct packed {
        logic       op;
        logic       rx_level;
        logic       tx_pending;
        logic [7:0] tx_byte;
        logic [6:0] prio_delay;
    } item_t;

    typedef struct packed {
        logic       tx_level;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_error;
        logic       tx_byte_taken;
        logic       tx_done;
        logic       collision;
        logic [2:0] send_status;
        logic [2:0] line_mode;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/cdbst_cfg.sv
// ----------------------------------------------------------------------------
// cdbst_cfg
// Configuration register bank written through the plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdbst_cfg
    import cdbst_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wen,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output cfg_t            cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_TICKS_PER_BIT:   cfg_next.ticks_per_bit      = cfg_data;
                CFG_FIRST_SAMPLE:    cfg_next.first_sample_ticks = cfg_data;
                CFG_CARRIER_TICKS:   cfg_next.carrier_ticks      = cfg_data[6:0];
                CFG_BACKOFF_LIMIT:   cfg_next.backoff_limit      = cfg_data[6:0];
                CFG_COLLISION_TICKS: cfg_next.collision_ticks    = cfg_data[6:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_bit      <= RST_TICKS_PER_BIT;
            cfg_reg.first_sample_ticks <= RST_FIRST_SAMPLE;
            cfg_reg.carrier_ticks      <= RST_CARRIER_TICKS;
            cfg_reg.backoff_limit      <= RST_BACKOFF_LIMIT;
            cfg_reg.collision_ticks    <= RST_COLLISION_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/cdbst_core.sv
// ----------------------------------------------------------------------------
// cdbst_core
// Line state registers and the single-pass update for one word: send
// request handling, edge detection, sub-bit timer, and the receive,
// transmit, backoff and collision bit events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdbst_core
    import cdbst_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  step,
    input  wire item_t item,
    output result_t    result
);

    mode_t      mode_reg,         mode_next;
    logic [6:0] bit_count_reg,    bit_count_next;
    logic [7:0] sub_tick_reg,     sub_tick_next;
    logic [7:0] sample_alarm_reg, sample_alarm_next;
    logic [7:0] rx_shift_reg,     rx_shift_next;
    logic [7:0] tx_shift_reg,     tx_shift_next;
    logic       tx_line_reg,      tx_line_next;
    logic       last_rx_reg,      last_rx_next;

    logic       start_edge;
    logic [8:0] tick_sum;
    logic       tx_clash;

    assign start_edge = last_rx_reg && !item.rx_level;
    assign tick_sum   = {1'b0, sub_tick_reg} + 9'd1;
    assign tx_clash   = ((bit_count_reg != '0) && (item.rx_level != tx_line_reg))
                     || ((bit_count_reg == '0) && !item.rx_level);

    always_comb
    begin
        mode_next         = mode_reg;
        bit_count_next    = bit_count_reg;
        sub_tick_next     = sub_tick_reg;
        sample_alarm_next = sample_alarm_reg;
        rx_shift_next     = rx_shift_reg;
        tx_shift_next     = tx_shift_reg;
        tx_line_next      = tx_line_reg;
        last_rx_next      = last_rx_reg;

        result               = '0;
        result.send_status   = STATUS_NONE;

        if (item.op)
        begin
            // A send request in backoff past its priority delay sees an idle bus.
            if ((mode_reg == MODE_BACKOFF) && (bit_count_reg >= item.prio_delay))
            begin
                sample_alarm_next  = cfg.ticks_per_bit;
                mode_next          = MODE_TX;
                bit_count_next     = '0;
                sub_tick_next      = '0;
                result.send_status = STATUS_STARTED;
            end
            else if (mode_reg == MODE_BACKOFF)
            begin
                result.send_status = (bit_count_reg < cfg.carrier_ticks) ?
                                     STATUS_CARRIER : STATUS_PRIORITY;
            end
            else if (mode_reg != MODE_IDLE)
            begin
                result.send_status = STATUS_BUSY;
            end
            else
            begin
                sample_alarm_next  = cfg.ticks_per_bit;
                mode_next          = MODE_TX;
                bit_count_next     = '0;
                sub_tick_next      = '0;
                result.send_status = STATUS_STARTED;
            end
        end
        else
        begin
            last_rx_next = item.rx_level;
            if (start_edge && ((mode_reg == MODE_IDLE) || (mode_reg == MODE_BACKOFF)))
            begin
                mode_next         = MODE_RX;
                bit_count_next    = '0;
                sub_tick_next     = '0;
                rx_shift_next     = '0;
                sample_alarm_next = cfg.first_sample_ticks;
            end
            else if (mode_reg != MODE_IDLE)
            begin
                if (tick_sum >= {1'b0, sample_alarm_reg})
                begin
                    sub_tick_next     = '0;
                    sample_alarm_next = cfg.ticks_per_bit;
                    unique case (mode_reg)
                        MODE_RX:
                        begin
                            if (bit_count_reg < DATA_BITS)
                            begin
                                rx_shift_next  = {item.rx_level, rx_shift_reg[7:1]};
                                bit_count_next = bit_count_reg + 7'd1;
                            end
                            else
                            begin
                                if (!item.rx_level)
                                begin
                                    result.rx_error = 1'b1;
                                    rx_shift_next   = '0;
                                end
                                else
                                begin
                                    result.rx_valid = 1'b1;
                                    result.rx_byte  = rx_shift_reg;
                                end
                                mode_next      = MODE_BACKOFF;
                                bit_count_next = '0;
                            end
                        end
                        MODE_TX:
                        begin
                            priority if (tx_clash)
                            begin
                                result.collision = 1'b1;
                                mode_next        = MODE_COLL;
                                bit_count_next   = '0;
                            end
                            else if (bit_count_reg == '0)
                            begin
                                if (item.tx_pending)
                                begin
                                    tx_shift_next        = item.tx_byte;
                                    tx_line_next         = 1'b0;
                                    bit_count_next       = 7'd1;
                                    result.tx_byte_taken = 1'b1;
                                end
                                else
                                begin
                                    result.tx_done = 1'b1;
                                    mode_next      = MODE_BACKOFF;
                                    bit_count_next = '0;
                                end
                            end
                            else if (bit_count_reg <= DATA_BITS)
                            begin
                                tx_line_next   = tx_shift_reg[0];
                                tx_shift_next  = {1'b0, tx_shift_reg[7:1]};
                                bit_count_next = bit_count_reg + 7'd1;
                            end
                            else
                            begin
                                // Stop bit: release the line and frame the next byte.
                                tx_line_next   = 1'b1;
                                bit_count_next = '0;
                            end
                        end
                        MODE_BACKOFF:
                        begin
                            if ((bit_count_reg > cfg.backoff_limit)
                                || (bit_count_reg == COUNT_MAX))
                            begin
                                mode_next      = MODE_IDLE;
                                bit_count_next = '0;
                            end
                            else
                            begin
                                bit_count_next = bit_count_reg + 7'd1;
                            end
                        end
                        default:
                        begin
                            // Collision break: hold the line low for the set count.
                            tx_line_next = 1'b0;
                            if (bit_count_reg == cfg.collision_ticks)
                            begin
                                tx_line_next   = 1'b1;
                                mode_next      = MODE_BACKOFF;
                                bit_count_next = '0;
                            end
                            else
                            begin
                                bit_count_next = bit_count_reg + 7'd1;
                            end
                        end
                    endcase
                end
                else
                begin
                    sub_tick_next = tick_sum[7:0];
                end
            end
        end

        result.tx_level  = tx_line_next;
        result.line_mode = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            bit_count_reg    <= '0;
            sub_tick_reg     <= '0;
            sample_alarm_reg <= RST_TICKS_PER_BIT;
            rx_shift_reg     <= '0;
            tx_shift_reg     <= '0;
            tx_line_reg      <= 1'b1;
            last_rx_reg      <= 1'b1;
        end
        else if (step)
        begin
            mode_reg         <= mode_next;
            bit_count_reg    <= bit_count_next;
            sub_tick_reg     <= sub_tick_next;
            sample_alarm_reg <= sample_alarm_next;
            rx_shift_reg     <= rx_shift_next;
            tx_shift_reg     <= tx_shift_next;
            tx_line_reg      <= tx_line_next;
            last_rx_reg      <= last_rx_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cd_backoff_serial_transceiver.sv
// ----------------------------------------------------------------------------
// cd_backoff_serial_transceiver
// Bit-level transceiver for a shared single-wire bus with carrier-detect
// and priority backoff, fed one line sample or send request per word.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Contents
//  s_*       in         s_tvalid/s_tready    tick or send request (tuser = op)
//  m_*       out        m_tvalid/m_tready    one result word per input word
//  cfg_*     in         cfg_wen              register index and write data
//
// Each input word is captured in an input register, processed by the line
// state logic in a single pass and written into the result register, so one
// word is taken every cycle unless the pipeline holds for back-pressure.
// The only loop is the line state register, updated in the same cycle the
// result is registered. When the result register is full and m_tready is low
// the pipeline holds, and a word is still taken while the input register is
// empty. Reset clears the line state and both valid flags, and returns the
// configuration to its power-on values.
//
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cd_backoff_serial_transceiver
    import cdbst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata, lowest bit up: rx_level, tx_pending, tx_byte[7:0],
    // prio_delay[6:0], seven bits of zero fill.
    input  wire logic [23:0] s_tdata,
    // s_tuser: op (0 timer tick with line sample, 1 send request).
    input  wire logic [0:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata, lowest bit up: tx_level, rx_valid, rx_byte[7:0], rx_error,
    // tx_byte_taken, tx_done, collision, send_status[2:0], line_mode[2:0],
    // four bits of zero fill.
    output logic [23:0]      m_tdata,

    input  wire logic        cfg_wen,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t out_result_reg;
    result_t core_result;
    logic    out_valid_reg;
    logic    advance;
    logic    s_accept;

    // The result register can take a new word when it is empty or being read.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    cdbst_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cdbst_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (in_valid_reg && advance),
        .item   (in_item_reg),
        .result (core_result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.op         <= s_tuser[0];
            in_item_reg.rx_level   <= s_tdata[0];
            in_item_reg.tx_pending <= s_tdata[1];
            in_item_reg.tx_byte    <= s_tdata[9:2];
            in_item_reg.prio_delay <= s_tdata[16:10];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       out_result_reg.line_mode,
                       out_result_reg.send_status,
                       out_result_reg.collision,
                       out_result_reg.tx_done,
                       out_result_reg.tx_byte_taken,
                       out_result_reg.rx_error,
                       out_result_reg.rx_byte,
                       out_result_reg.rx_valid,
                       out_result_reg.tx_level};

endmodule

`default_nettype wire
